FILE: src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: src/pqwd_pkg.sv
`default_nettype none
package pqwd_pkg;

   localparam int NUM_SERVERS_DEF = 5;
   localparam int FIFO_DEPTH_DEF  = 16;
   localparam int NUM_CLASSES     = 3;

   localparam int JOB_W    = 16;
   localparam int TIME_W   = 8;
   localparam int CLASS_W  = 2;
   localparam int STATUS_W = 2;
   localparam int SRV_IDX_W = 4;

   // request class codes
   localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;

   // admit status codes
   localparam logic [STATUS_W-1:0] ADMIT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ADMIT_DROPPED = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] svc_time;
      logic [JOB_W-1:0]  job_id;
   } entry_type;

   typedef struct packed {
      logic              busy;
      logic [JOB_W-1:0]  job;
      logic [TIME_W-1:0] rem;
   } srv_type;

   typedef struct packed {
      logic                   push;
      logic [CLASS_W-1:0]     push_cls;
      entry_type              push_data;
      logic                   pop;
      logic [CLASS_W-1:0]     pop_cls;
   } fifo_cmd_type;

   typedef struct packed {
      logic [NUM_CLASSES-1:0] nonempty;
      logic [NUM_CLASSES-1:0] full;
   } fifo_stat_type;

endpackage
`default_nettype wire

FILE: src/pqwd_cell.sv
`default_nettype none
module pqwd_cell
   import pqwd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    shift_en,
   input  wire srv_type cell_in,
   output srv_type      cell_out
);

   logic              busy_ff;
   logic [JOB_W-1:0]  job_ff;
   logic [TIME_W-1:0] rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (shift_en) begin
         busy_ff <= cell_in.busy;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         job_ff <= cell_in.job;
         rem_ff <= cell_in.rem;
      end
   end

   assign cell_out = '{busy: busy_ff, job: job_ff, rem: rem_ff};

endmodule
`default_nettype wire

FILE: src/pqwd_class_fifo.sv
`default_nettype none
module pqwd_class_fifo
   import pqwd_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire fifo_cmd_type cmd,
   output fifo_stat_type     stat,
   output entry_type         rd_data
);

   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_CLASSES * FIFO_DEPTH);
   localparam int SUM_W  = CNT_W + 1;

   entry_type        mem [NUM_CLASSES*FIFO_DEPTH];
   entry_type        rd_data_ff;
   logic [PTR_W-1:0] head_ff  [NUM_CLASSES];
   logic [PTR_W-1:0] head_in  [NUM_CLASSES];
   logic [CNT_W-1:0] count_ff [NUM_CLASSES];
   logic [CNT_W-1:0] count_in [NUM_CLASSES];

   logic              do_push;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   always_comb begin
      logic [SUM_W-1:0] tail_sum;
      logic [PTR_W-1:0] tail;
      logic             push_c;
      logic             pop_c;
      do_push = 1'b0;
      wr_addr = '0;
      rd_addr = '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         stat.full[c]     = (count_ff[c] == CNT_W'(FIFO_DEPTH));
         stat.nonempty[c] = (count_ff[c] != '0);
         tail_sum = SUM_W'(head_ff[c]) + SUM_W'(count_ff[c]);
         if (tail_sum >= SUM_W'(FIFO_DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(FIFO_DEPTH);
         end
         tail   = tail_sum[PTR_W-1:0];
         push_c = cmd.push && (cmd.push_cls == CLASS_W'(c)) && !stat.full[c];
         pop_c  = cmd.pop && (cmd.pop_cls == CLASS_W'(c));
         if (push_c) begin
            do_push = 1'b1;
            wr_addr = ADDR_W'(c * FIFO_DEPTH) + ADDR_W'(tail);
         end
         if (pop_c) begin
            rd_addr = ADDR_W'(c * FIFO_DEPTH) + ADDR_W'(head_ff[c]);
         end
         head_in[c] = head_ff[c];
         if (pop_c) begin
            head_in[c] = (head_ff[c] == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff[c] + 1'b1;
         end
         count_in[c] = count_ff[c];
         if (push_c && !pop_c) begin
            count_in[c] = count_ff[c] + 1'b1;
         end else if (pop_c && !push_c) begin
            count_in[c] = count_ff[c] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= head_in[c];
            count_ff[c] <= count_in[c];
         end
      end
   end

   // storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_addr] <= cmd.push_data;
      end
      if (cmd.pop) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/priority_queue_ward_dispatcher_top.sv
// Three-class strict-priority dispatcher for a bank of NUM_SERVERS servers.
// Each request word may admit one job (class 1 critical, 2 serious,
// 3 stable; class 0 is a plain tick) into that class's FIFO, then runs one
// tick: servers are visited in index order, a busy server counts down and
// frees at zero, and a free server takes the head of the highest non-empty
// class. A job placed this tick first counts down on the next tick. Every
// request yields NUM_SERVERS response words, server 0 first, the last one
// with rsp_tlast high. A zero service time is stored as one; a job arriving
// at a full FIFO is dropped and every response word of that request reports
// admit_status 2. The request is accepted in the idle state, then each
// server is visited in turn, and each server that is refilled from a FIFO
// takes an extra fetch state (the class FIFO storage has a registered read
// port); back-pressure on the response side stretches the visits.
// The server state lives in a ring of cells that rotates one place per visit,
// so the server under service is always at cell 0.
`default_nettype none
`include "assert_macros.svh"
module priority_queue_ward_dispatcher_top
   import pqwd_pkg::*;
#(
   parameter int NUM_SERVERS = NUM_SERVERS_DEF,
   parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [23:0]         req_tdata,  // [15:0] job_id, [23:16] service_time
   input  wire logic [CLASS_W-1:0]  req_tuser,  // [1:0] priority_class
   // response channel
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // [3:0] server_index, [4] server_busy, [20:5] occupant_id,
   // [22:21] admit_status, [23] zero
   output logic [23:0]              rsp_tdata,
   output logic                     rsp_tlast   // last_server
);

   localparam int IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_VISIT = 3'b010,
      ST_FETCH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   // response word register
   logic                 out_valid_ff, out_valid_in;
   logic [SRV_IDX_W-1:0] out_index_ff;
   logic                 out_busy_ff;
   logic [JOB_W-1:0]     out_id_ff;
   logic [STATUS_W-1:0]  out_status_ff;
   logic                 out_last_ff;

   // server ring
   srv_type              chain_q [NUM_SERVERS];
   srv_type              wb;
   logic                 shift_en;

   fifo_cmd_type         fifo_cmd;
   fifo_stat_type        fifo_stat;
   entry_type            fifo_rd;

   logic                 accept;
   logic                 out_free;
   logic                 keep_busy;
   logic                 any_ne;
   logic                 is_last;
   logic [CLASS_W-1:0]   pick_cls;
   logic [TIME_W-1:0]    svc_fixed;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign any_ne     = |fifo_stat.nonempty;
   assign is_last    = (cnt_ff == IDX_W'(NUM_SERVERS - 1));
   // head cell after its countdown
   assign keep_busy  = chain_q[0].busy && (chain_q[0].rem > TIME_W'(1));
   assign svc_fixed  = (req_tdata[23:16] == '0) ? TIME_W'(1) : req_tdata[23:16];

   always_comb begin
      priority if (fifo_stat.nonempty[0]) begin
         pick_cls = CLASS_W'(0);
      end else if (fifo_stat.nonempty[1]) begin
         pick_cls = CLASS_W'(1);
      end else begin
         pick_cls = CLASS_W'(2);
      end
   end

   always_comb begin
      state_in           = state_ff;
      cnt_in             = cnt_ff;
      status_in          = status_ff;
      shift_en           = 1'b0;
      wb                 = chain_q[0];
      fifo_cmd.push      = accept && (req_tuser != CLASS_NONE);
      fifo_cmd.push_cls  = req_tuser - 1'b1;
      fifo_cmd.push_data = '{svc_time: svc_fixed, job_id: req_tdata[15:0]};
      fifo_cmd.pop       = 1'b0;
      fifo_cmd.pop_cls   = pick_cls;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in    = '0;
               status_in = (fifo_cmd.push && fifo_stat.full[fifo_cmd.push_cls])
                           ? ADMIT_DROPPED : ADMIT_OK;
               state_in  = ST_VISIT;
            end
         end
         ST_VISIT: begin
            if (out_free) begin
               if (!keep_busy && any_ne) begin
                  // refill: head entry shows up next cycle
                  fifo_cmd.pop = 1'b1;
                  state_in     = ST_FETCH;
               end else begin
                  shift_en = 1'b1;
                  wb.busy  = keep_busy;
                  wb.rem   = keep_busy ? chain_q[0].rem - 1'b1 : '0;
               end
            end
         end
         ST_FETCH: begin
            shift_en = 1'b1;
            wb.busy  = 1'b1;
            wb.job   = fifo_rd.job_id;
            wb.rem   = fifo_rd.svc_time;
            state_in = ST_VISIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (shift_en) begin
         if (is_last) begin
            cnt_in   = '0;
            state_in = ST_IDLE;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         status_ff <= ADMIT_OK;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
   end

   // response register: loaded on every visit that completes
   always_comb begin
      out_valid_in = out_valid_ff;
      if (shift_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         out_index_ff  <= SRV_IDX_W'(cnt_ff);
         out_busy_ff   <= wb.busy;
         out_id_ff     <= wb.busy ? wb.job : '0;
         out_status_ff <= status_ff;
         out_last_ff   <= is_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_status_ff, out_id_ff, out_busy_ff, out_index_ff};
   assign rsp_tlast  = out_last_ff;

   // ring of server cells, rotating toward cell 0
   for (genvar i = 0; i < NUM_SERVERS; i++) begin : g_cell
      srv_type nb_in;
      if (i == NUM_SERVERS - 1) begin : g_tail
         assign nb_in = wb;
      end else begin : g_mid
         assign nb_in = chain_q[i+1];
      end
      pqwd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .cell_in  (nb_in),
         .cell_out (chain_q[i])
      );
   end

   pqwd_class_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .cmd     (fifo_cmd),
      .stat    (fifo_stat),
      .rd_data (fifo_rd)
   );

   // checks
   `ASSERT_NEXT(a_accept_starts_tick, clock, reset, accept, (state_ff == ST_VISIT) && (cnt_ff == '0))
   `ASSERT_IMPL(a_fetch_out_empty, clock, reset, state_ff == ST_FETCH, !out_valid_ff)
   `ASSERT_IMPL(a_pop_nonempty, clock, reset, fifo_cmd.pop, fifo_stat.nonempty[fifo_cmd.pop_cls])
   `ASSERT_NEXT(a_last_ends_tick, clock, reset, shift_en && is_last, state_ff == ST_IDLE && rsp_tlast)

endmodule
`default_nettype wire

FILE: sim/priority_queue_ward_dispatcher_top_tb.sv
// Checks the three-class dispatcher against a cycle-free predictor.
// Every accepted request word is run through the predictor, which queues
// one report per server; each response word is matched against the oldest
// queued report. A short directed table comes first, then random traffic
// under several idling mixes and one long response stall.
`default_nettype none
module priority_queue_ward_dispatcher_top_tb;
   import pqwd_pkg::*;

   localparam int NSRV   = NUM_SERVERS_DEF;
   localparam int FDEPTH = FIFO_DEPTH_DEF;

   // class codes above CLASS_NONE
   localparam logic [CLASS_W-1:0] CLASS_CRITICAL = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_SERIOUS  = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_STABLE   = 2'd3;

   localparam int RANDOM_WORDS = 245;
   localparam int HOLD_CYCLES  = 300;           // long response stall
   localparam int DRAIN_CYCLES = 4 * NSRV + 8;  // extra wait after the last expected report
   localparam int MAX_SHOWN    = 10;

   // one row of the directed table; typed rows carry a hand-written
   // busy map, admit status and server 0 occupant
   typedef struct packed {
      logic [CLASS_W-1:0]  cls;
      logic [JOB_W-1:0]    id;
      logic [TIME_W-1:0]   svc;
      logic                typed;
      logic [NSRV-1:0]     busy_mask;
      logic [JOB_W-1:0]    occ0;
      logic [STATUS_W-1:0] status;
   } stim_row_type;

   // one server report, as carried by a response word
   typedef struct packed {
      logic [SRV_IDX_W-1:0] idx;
      logic                 busy;
      logic [JOB_W-1:0]     occ;
      logic [STATUS_W-1:0]  status;
      logic                 last;
   } report_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic [23:0]         req_tdata  = '0;
   logic [CLASS_W-1:0]  req_tuser  = CLASS_NONE;
   logic                rsp_tready = 1'b0;
   wire                 req_tready;
   wire                 rsp_tvalid;
   wire  [23:0]         rsp_tdata;
   wire                 rsp_tlast;

   priority_queue_ward_dispatcher_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] job_id, [23:16] service_time
      .req_tuser  (req_tuser),   // [1:0] priority_class
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [3:0] index, [4] busy, [20:5] occupant, [22:21] status
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Predictor state: one job queue per class, one record per server
   // ---------------------------------------------------------------
   entry_type  class_fifo[NUM_CLASSES][$];
   srv_type    server_state[NSRV];
   report_type expected_reports[$];

   int  mismatches    = 0;
   int  words_sent    = 0;
   int  words_checked = 0;
   int  idle_phase    = 0;   // 0 none, 1 sender, 2 receiver, 3 both
   logic hold_off     = 1'b0;

   function automatic bit roll(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // Admit (or drop) the job, run one tick over the servers in index
   // order, then queue the report of every server.
   function automatic void predict_dispatch(input logic [CLASS_W-1:0] cls,
                                            input logic [JOB_W-1:0] id,
                                            input logic [TIME_W-1:0] svc);
      logic [STATUS_W-1:0] status;
      entry_type           e;
      report_type          r;
      status = ADMIT_OK;
      if (cls != CLASS_NONE) begin
         e.job_id   = id;
         e.svc_time = (svc == '0) ? TIME_W'(1) : svc;   // zero time runs one tick
         if (class_fifo[int'(cls) - 1].size() >= FDEPTH)
            status = ADMIT_DROPPED;
         else
            class_fifo[int'(cls) - 1].push_back(e);
      end
      for (int s = 0; s < NSRV; s++) begin
         if (server_state[s].busy) begin
            if (server_state[s].rem <= 1) begin
               server_state[s].busy = 1'b0;
               server_state[s].rem  = '0;
            end else begin
               server_state[s].rem = server_state[s].rem - 1'b1;
            end
         end
         // refill straight away; the new job counts down from next tick
         if (!server_state[s].busy) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
               if (class_fifo[c].size() != 0) begin
                  e = class_fifo[c].pop_front();
                  server_state[s].busy = 1'b1;
                  server_state[s].job  = e.job_id;
                  server_state[s].rem  = e.svc_time;
                  break;
               end
            end
         end
      end
      for (int s = 0; s < NSRV; s++) begin
         r.idx    = SRV_IDX_W'(s);
         r.busy   = server_state[s].busy;
         r.occ    = server_state[s].busy ? server_state[s].job : '0;
         r.status = status;
         r.last   = (s == NSRV - 1);
         expected_reports.push_back(r);
      end
   endfunction

   function automatic void note_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
      if (want !== seen) begin
         mismatches++;
         if (mismatches <= MAX_SHOWN)
            $display("mismatch in %s of word %0d: expected %0h, got %0h",
                     name, words_checked, want, seen);
      end
   endfunction

   function automatic void check_report();
      report_type want;
      if (expected_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_SHOWN)
            $display("unexpected response word %0h (last %b)", rsp_tdata, rsp_tlast);
      end else begin
         want = expected_reports.pop_front();
         note_field("server_index", 32'(want.idx), 32'(rsp_tdata[3:0]));
         note_field("server_busy", 32'(want.busy), 32'(rsp_tdata[4]));
         note_field("occupant_id", 32'(want.occ), 32'(rsp_tdata[20:5]));
         note_field("admit_status", 32'(want.status), 32'(rsp_tdata[22:21]));
         note_field("pad bit", 32'd0, 32'(rsp_tdata[23]));
         note_field("last_server", 32'(want.last), 32'(rsp_tlast));
      end
      words_checked++;
   endfunction

   function automatic int sender_idle_pct();
      return (idle_phase == 1) ? 48 : (idle_phase == 3) ? 15 : 0;
   endfunction

   function automatic int receiver_stall_pct();
      return (idle_phase == 2) ? 48 : (idle_phase == 3) ? 15 : 0;
   endfunction

   // ---------------------------------------------------------------
   // Response side: check on every accepted word, then pick next ready
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_report();
      rsp_tready <= !hold_off && !roll(receiver_stall_pct());
   end

   // Long stall mid-run: the sender keeps offering, so the block has to
   // back up into its request port.
   initial begin
      while (words_sent < 25 + RANDOM_WORDS / 2) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Request side: optional idle cycles, then hold the word until taken.
   // valid is only ever dropped on an idle cycle, so it never gets two
   // updates in one step.
   task automatic send_word(input logic [CLASS_W-1:0] cls, input logic [JOB_W-1:0] id,
                            input logic [TIME_W-1:0] svc);
      while (roll(sender_idle_pct())) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cls;
      req_tdata  <= {svc, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_dispatch(cls, id, svc);
      words_sent++;
   endtask

   function automatic stim_row_type row(input logic [CLASS_W-1:0] cls,
                                        input logic [JOB_W-1:0] id,
                                        input logic [TIME_W-1:0] svc, input logic typed,
                                        input logic [NSRV-1:0] busy_mask,
                                        input logic [JOB_W-1:0] occ0,
                                        input logic [STATUS_W-1:0] status);
      stim_row_type r;
      r.cls = cls; r.id = id; r.svc = svc; r.typed = typed;
      r.busy_mask = busy_mask; r.occ0 = occ0; r.status = status;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      stim_row_type       directed_rows[$];
      stim_row_type       r;
      int                 base;
      int                 pick;
      logic [CLASS_W-1:0] cls;
      logic [TIME_W-1:0]  svc;

      for (int s = 0; s < NSRV; s++) server_state[s] = '0;

      // after reset: plain tick, every server idle
      directed_rows.push_back(row(CLASS_NONE, 16'h0000, 8'h00, 1'b1, '0, 16'h0000, ADMIT_OK));
      // zero service time: goes straight onto server 0 ...
      directed_rows.push_back(row(CLASS_CRITICAL, 16'hFFFF, 8'h00, 1'b1, 5'b00001, 16'hFFFF,
                                  ADMIT_OK));
      // ... and leaves after a single countdown; tick word with junk payload
      directed_rows.push_back(row(CLASS_NONE, 16'hFFFF, 8'hFF, 1'b1, '0, 16'h0000, ADMIT_OK));
      // busy server whose occupant id is zero
      directed_rows.push_back(row(CLASS_STABLE, 16'h0000, 8'd24, 1'b1, 5'b00001, 16'h0000,
                                  ADMIT_OK));
      // occupy the remaining servers with long jobs
      directed_rows.push_back(row(CLASS_SERIOUS, 16'h1234, 8'd24, 1'b0, '0, '0, ADMIT_OK));
      directed_rows.push_back(row(CLASS_SERIOUS, 16'h5678, 8'd24, 1'b0, '0, '0, ADMIT_OK));
      directed_rows.push_back(row(CLASS_SERIOUS, 16'h9ABC, 8'd24, 1'b0, '0, '0, ADMIT_OK));
      directed_rows.push_back(row(CLASS_SERIOUS, 16'hDEF0, 8'd24, 1'b0, '0, '0, ADMIT_OK));
      // fill the critical queue while no server can take a job
      for (int k = 0; k < FDEPTH; k++)
         directed_rows.push_back(row(CLASS_CRITICAL, 16'h8000 | JOB_W'(k * 16'h0911),
                                     TIME_W'(k), 1'b0, '0, '0, ADMIT_OK));
      // full queue: job dropped, tick still runs with all servers busy
      directed_rows.push_back(row(CLASS_CRITICAL, 16'hFFFF, 8'hFF, 1'b1, 5'b11111, 16'h0000,
                                  ADMIT_DROPPED));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         send_word(r.cls, r.id, r.svc);
         // typed rows: hand-written values take the place of predicted ones
         if (r.typed) begin
            base = expected_reports.size() - NSRV;
            for (int s = 0; s < NSRV; s++) begin
               expected_reports[base + s].busy   = r.busy_mask[s];
               expected_reports[base + s].status = r.status;
               if (s == 0)
                  expected_reports[base].occ = r.occ0;
            end
         end
      end

      // Random traffic: a quarter plain ticks, mostly short jobs with a
      // few long ones so the queues fill up and drops happen now and then.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         idle_phase = (i * 4) / RANDOM_WORDS;
         pick = $urandom_range(0, 99);
         cls  = (pick < 25) ? CLASS_NONE : CLASS_W'($urandom_range(1, 3));
         pick = $urandom_range(0, 99);
         if (pick < 2)
            svc = TIME_W'($urandom_range(0, 255));
         else if (pick < 10)
            svc = TIME_W'($urandom_range(11, 40));
         else
            svc = TIME_W'($urandom_range(0, 8));
         send_word(cls, JOB_W'($urandom_range(0, 65535)), svc);
      end
      req_tvalid <= 1'b0;

      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
+incdir+src
src/pqwd_pkg.sv
src/pqwd_cell.sv
src/pqwd_class_fifo.sv
src/priority_queue_ward_dispatcher_top.sv
sim/priority_queue_ward_dispatcher_top_tb.sv
